// ----- rtl/pit_pkg.sv -----
package pit_pkg;

  typedef enum logic [1:0] {
    FN_TICK  = 2'd0,
    FN_READ  = 2'd1,
    FN_WRITE = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    OFF_TICKS     = 3'd0,
    OFF_INTERVAL  = 3'd1,
    OFF_ENABLE    = 3'd2,
    OFF_VECTOR    = 3'd3,
    OFF_PAYLOAD   = 3'd4,
    OFF_IRQ_COUNT = 3'd5
  } offset_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_OFFSET = 2'd1,
    ST_BAD_VALUE  = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_INTERVAL = 2'd0,
    CFG_VECTOR   = 2'd1,
    CFG_PAYLOAD  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  localparam int DataW    = 64;
  localparam int VecW     = 8;
  localparam int DivSteps = DataW;
  localparam int CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  // controller -> datapath
  typedef struct packed {
    logic take;    // execute the accepted transaction
    logic step;    // one restoring-division step
    logic finish;  // post the interrupt decision
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/pit_if.sv -----
interface pit_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [2:0]        offset;
  logic signed [63:0] write_value;

  modport source (output valid, output func, output offset, output write_value, input ready);
  modport sink   (input valid, input func, input offset, input write_value, output ready);
endinterface

interface pit_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] read_data;
  logic               irq_valid;
  logic [7:0]         irq_vector;
  logic signed [63:0] irq_payload;

  modport source (output valid, output status, output read_data, output irq_valid,
                  output irq_vector, output irq_payload, input ready);
  modport sink   (input valid, input status, input read_data, input irq_valid,
                  input irq_vector, input irq_payload, output ready);
endinterface

// ----- rtl/pit_ctrl.sv -----
module pit_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pit_pkg::sts_t sts,
  output pit_pkg::cmd_t cmd
);

  pit_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pit_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state_r)
      pit_pkg::S_IDLE: begin
        // take a transaction only when its result has a place to land
        in_ready = sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.take = 1'b1;
          if (sts.need_div) state_nxt = pit_pkg::S_DIV;
        end
      end
      pit_pkg::S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) state_nxt = pit_pkg::S_FIN;
      end
      pit_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = pit_pkg::S_IDLE;
        end
      end
      default: state_nxt = pit_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/pit_dp.sv -----
module pit_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pit_pkg::cmd_t      cmd,
  output pit_pkg::sts_t      sts,
  input  logic [1:0]         in_func,
  input  logic [2:0]         in_offset,
  input  logic signed [63:0] in_write_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [63:0] out_read_data,
  output logic               out_irq_valid,
  output logic [7:0]         out_irq_vector,
  output logic signed [63:0] out_irq_payload
);

  localparam int W  = pit_pkg::DataW;
  localparam int VW = pit_pkg::VecW;

  // architectural state
  logic [W-1:0]  tick_total_r;
  logic [W-1:0]  period_r;
  logic          enable_r;
  logic [VW-1:0] vec_r;
  logic [W-1:0]  payload_r;
  logic [W-1:0]  raised_r;

  // divider
  logic [W-1:0]              q_r;
  logic [W-1:0]              rem_r, rem_nxt;
  logic [pit_pkg::CntW-1:0]  cnt_r;
  logic [W:0]                trial, diff;

  // result register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [W-1:0]  out_read_data_r;
  logic          out_irq_valid_r;
  logic [VW-1:0] out_irq_vector_r;
  logic [W-1:0]  out_irq_payload_r;

  logic [W-1:0]  wv;
  logic [W-1:0]  tick_inc;
  logic          tick_max;
  logic          rem_zero;

  pit_pkg::status_t res_status;
  logic [W-1:0]     res_data;
  logic             do_tick;
  logic             wr_ticks, wr_interval, wr_enable, wr_vector, wr_payload, clr_count;

  assign wv       = in_write_value;
  assign tick_max = &tick_total_r;
  assign tick_inc = tick_total_r + W'(1);
  assign rem_zero = (rem_r == '0);

  assign sts.need_div = (in_func == pit_pkg::FN_TICK) && !tick_max && enable_r;
  assign sts.div_done = (cnt_r == pit_pkg::DivLast);
  assign sts.out_free = !out_valid_r || out_ready;

  // restoring division: bring down one dividend bit per step
  always_comb begin
    trial = {rem_r, q_r[W-1]};
    diff  = trial - {1'b0, period_r};
    if (!diff[W]) rem_nxt = diff[W-1:0];
    else          rem_nxt = trial[W-1:0];
  end

  always_comb begin
    res_status  = pit_pkg::ST_OK;
    res_data    = '0;
    do_tick     = 1'b0;
    wr_ticks    = 1'b0;
    wr_interval = 1'b0;
    wr_enable   = 1'b0;
    wr_vector   = 1'b0;
    wr_payload  = 1'b0;
    clr_count   = 1'b0;
    case (in_func)
      pit_pkg::FN_TICK: begin
        if (tick_max) res_status = pit_pkg::ST_OVERFLOW;
        else          do_tick    = 1'b1;
      end
      pit_pkg::FN_READ: begin
        case (in_offset)
          pit_pkg::OFF_TICKS:     res_data = tick_total_r;
          pit_pkg::OFF_INTERVAL:  res_data = period_r;
          pit_pkg::OFF_ENABLE:    res_data = W'(enable_r);
          pit_pkg::OFF_VECTOR:    res_data = W'(vec_r);
          pit_pkg::OFF_PAYLOAD:   res_data = payload_r;
          pit_pkg::OFF_IRQ_COUNT: res_data = raised_r;
          default:                res_status = pit_pkg::ST_BAD_OFFSET;
        endcase
      end
      pit_pkg::FN_WRITE: begin
        case (in_offset)
          pit_pkg::OFF_TICKS: begin
            if (wv[W-1]) res_status = pit_pkg::ST_BAD_VALUE;
            else         wr_ticks   = 1'b1;
          end
          pit_pkg::OFF_INTERVAL: begin
            if (wv[W-1] || wv == '0) res_status  = pit_pkg::ST_BAD_VALUE;
            else                     wr_interval = 1'b1;
          end
          pit_pkg::OFF_ENABLE: wr_enable = 1'b1;
          pit_pkg::OFF_VECTOR: begin
            if (|wv[W-1:VW]) res_status = pit_pkg::ST_BAD_VALUE;
            else             wr_vector  = 1'b1;
          end
          pit_pkg::OFF_PAYLOAD: wr_payload = 1'b1;
          pit_pkg::OFF_IRQ_COUNT: begin
            // count may only be cleared
            if (wv != '0) res_status = pit_pkg::ST_BAD_VALUE;
            else          clr_count  = 1'b1;
          end
          default: res_status = pit_pkg::ST_BAD_OFFSET;
        endcase
      end
      default: res_status = pit_pkg::ST_BAD_OFFSET;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_total_r <= '0;
      period_r     <= W'(1);
      enable_r     <= 1'b1;
      vec_r        <= '0;
      payload_r    <= '0;
      raised_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pit_pkg::CFG_INTERVAL: if (cfg_data != '0) period_r <= cfg_data;
        pit_pkg::CFG_VECTOR:   vec_r     <= cfg_data[VW-1:0];
        pit_pkg::CFG_PAYLOAD:  payload_r <= cfg_data;
        default: ;
      endcase
    end else if (cmd.take) begin
      if (do_tick)     tick_total_r <= tick_inc;
      if (wr_ticks)    tick_total_r <= wv;
      if (wr_interval) period_r     <= wv;
      if (wr_enable)   enable_r     <= (wv != '0);
      if (wr_vector)   vec_r        <= wv[VW-1:0];
      if (wr_payload)  payload_r    <= wv;
      if (clr_count)   raised_r     <= '0;
    end else if (cmd.finish && rem_zero) begin
      raised_r <= raised_r + W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      q_r   <= tick_inc;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.step) begin
      q_r   <= {q_r[W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + pit_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.take && !sts.need_div) || cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && !sts.need_div) begin
      out_status_r      <= res_status;
      out_read_data_r   <= res_data;
      out_irq_valid_r   <= 1'b0;
      out_irq_vector_r  <= '0;
      out_irq_payload_r <= '0;
    end else if (cmd.finish) begin
      out_status_r      <= pit_pkg::ST_OK;
      out_read_data_r   <= '0;
      out_irq_valid_r   <= rem_zero;
      out_irq_vector_r  <= rem_zero ? vec_r : '0;
      out_irq_payload_r <= rem_zero ? payload_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_data   = out_read_data_r;
  assign out_irq_valid   = out_irq_valid_r;
  assign out_irq_vector  = out_irq_vector_r;
  assign out_irq_payload = out_irq_payload_r;

endmodule

// ----- rtl/periodic_interrupt_timer.sv -----
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    func[1:0], offset[2:0], write_value[63:0]
// out_ch    out  valid/ready    status[1:0], read_data[63:0], irq_valid,
//                               irq_vector[7:0], irq_payload[63:0]
// cfg_*     in   cfg_we         cfg_index[1:0], cfg_data[63:0]
//
// Reads, writes, rejected accesses, overflowing ticks and ticks while disabled
// are posted in the cycle after acceptance. An enabled tick is accepted, runs
// 64 radix-2 remainder steps against the interval and then posts its result.
// A result waits in the output register; the next transaction is accepted in
// the cycle the waiting result is taken. Reset (rst_n low, synchronous) loads
// interval 1, vector 0, payload 0, enable 1 and clears both counters.
module periodic_interrupt_timer (
  input  logic        clk,
  input  logic        rst_n,
  pit_in_if.sink      in_ch,
  pit_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  pit_pkg::cmd_t cmd;
  pit_pkg::sts_t sts;

  pit_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pit_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_ch.func),
    .in_offset       (in_ch.offset),
    .in_write_value  (in_ch.write_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_read_data   (out_ch.read_data),
    .out_irq_valid   (out_ch.irq_valid),
    .out_irq_vector  (out_ch.irq_vector),
    .out_irq_payload (out_ch.irq_payload)
  );

endmodule

// ----- rtl/pit_checker.sv -----
module pit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_read_data,
  input logic        out_irq_valid,
  input logic [7:0]  out_irq_vector,
  input logic [63:0] out_irq_payload
);

  // result channel comes up empty out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // input is only taken when the result slot is free
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready with result slot occupied");

  // interrupt only on a clean tick, fields zero otherwise
  a_irq_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_valid |-> out_status == pit_pkg::ST_OK && out_read_data == '0)
    else $error("interrupt with error status or read data");

  a_irq_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_irq_valid |-> out_irq_vector == '0 && out_irq_payload == '0)
    else $error("interrupt fields set without interrupt");

endmodule

bind periodic_interrupt_timer pit_checker u_pit_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_read_data   (out_ch.read_data),
  .out_irq_valid   (out_ch.irq_valid),
  .out_irq_vector  (out_ch.irq_vector),
  .out_irq_payload (out_ch.irq_payload)
);

// ----- bench/tb.sv -----
module tb;

  localparam logic [1:0]  FN_UNUSED        = 2'd3;
  localparam logic [2:0]  OFF_SPARE0       = 3'd6;
  localparam logic [2:0]  OFF_SPARE1       = 3'd7;
  localparam logic [1:0]  CFG_UNUSED       = 2'd3;
  localparam logic [63:0] MAX_POS          = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG          = 64'h8000_0000_0000_0000;
  localparam int          RANDOM_PER_PHASE = 225;
  localparam int          SETTLE_CYCLES    = 70;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          CYCLE_LIMIT      = 1_000_000;
  localparam int          PRINT_LIMIT      = 40;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  offset;
    logic [63:0] wdata;
  } bus_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_data;
    logic        irq_valid;
    logic [7:0]  irq_vector;
    logic [63:0] irq_payload;
  } timer_reply_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_TOGGLE, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  pit_in_if  in_ch();
  pit_out_if out_ch();

  periodic_interrupt_timer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // transactions waiting to be offered, and replies the timer still owes
  bus_op_t      bus_ops[$];
  timer_reply_t timer_replies[$];

  // predicted timer state, starting from its reset values
  logic [63:0] tick_cnt  = '0;
  logic [63:0] period_r  = 64'd1;
  logic        timer_on  = 1'b1;
  logic [7:0]  vec_r     = '0;
  logic [63:0] payload_r = '0;
  logic [63:0] irq_cnt   = '0;

  logic in_fire = 1'b0;
  int   mismatches = 0;
  int   reply_cnt = 0;
  int   taken_cnt = 0;
  int   cycle_cnt = 0;

  function automatic timer_reply_t advance_timer(bus_op_t op);
    timer_reply_t r;
    r = '0;
    case (op.func)
      pit_pkg::FN_TICK: begin
        if (&tick_cnt) begin
          r.status = pit_pkg::ST_OVERFLOW;
        end else begin
          tick_cnt = tick_cnt + 64'd1;
          if (timer_on && (tick_cnt % period_r) == '0) begin
            r.irq_valid   = 1'b1;
            r.irq_vector  = vec_r;
            r.irq_payload = payload_r;
            irq_cnt       = irq_cnt + 64'd1;
          end
        end
      end
      pit_pkg::FN_READ: begin
        case (op.offset)
          pit_pkg::OFF_TICKS:     r.read_data = tick_cnt;
          pit_pkg::OFF_INTERVAL:  r.read_data = period_r;
          pit_pkg::OFF_ENABLE:    r.read_data = {63'd0, timer_on};
          pit_pkg::OFF_VECTOR:    r.read_data = {56'd0, vec_r};
          pit_pkg::OFF_PAYLOAD:   r.read_data = payload_r;
          pit_pkg::OFF_IRQ_COUNT: r.read_data = irq_cnt;
          default:                r.status = pit_pkg::ST_BAD_OFFSET;
        endcase
      end
      pit_pkg::FN_WRITE: begin
        case (op.offset)
          pit_pkg::OFF_TICKS: begin
            if (op.wdata[63]) r.status = pit_pkg::ST_BAD_VALUE;
            else tick_cnt = op.wdata;
          end
          pit_pkg::OFF_INTERVAL: begin
            if (op.wdata[63] || op.wdata == '0) r.status = pit_pkg::ST_BAD_VALUE;
            else period_r = op.wdata;
          end
          pit_pkg::OFF_ENABLE: timer_on = |op.wdata;
          pit_pkg::OFF_VECTOR: begin
            if (op.wdata > 64'd255) r.status = pit_pkg::ST_BAD_VALUE;
            else vec_r = op.wdata[7:0];
          end
          pit_pkg::OFF_PAYLOAD: payload_r = op.wdata;
          pit_pkg::OFF_IRQ_COUNT: begin
            // the interrupt count may only be cleared
            if (op.wdata != '0) r.status = pit_pkg::ST_BAD_VALUE;
            else irq_cnt = '0;
          end
          default: r.status = pit_pkg::ST_BAD_OFFSET;
        endcase
      end
      default: r.status = pit_pkg::ST_BAD_OFFSET;
    endcase
    return r;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [63:0] data);
    case (idx)
      pit_pkg::CFG_INTERVAL: if (data != '0) period_r = data;
      pit_pkg::CFG_VECTOR:   vec_r = data[7:0];
      pit_pkg::CFG_PAYLOAD:  payload_r = data;
      default:               ;
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic bus_op_t mk_op(logic [1:0] f, logic [2:0] o, logic [63:0] w);
    bus_op_t op;
    op.func   = f;
    op.offset = o;
    op.wdata  = w;
    return op;
  endfunction

  // bias toward small intervals and tick counts so interrupts fire often
  function automatic bus_op_t random_op();
    bus_op_t     op;
    int          pick;
    logic [63:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 45) op.func = pit_pkg::FN_TICK;
    else if (pick < 70) op.func = pit_pkg::FN_READ;
    else if (pick < 96) op.func = pit_pkg::FN_WRITE;
    else op.func = FN_UNUSED;
    if ($urandom_range(0, 9) == 0) op.offset = 3'($urandom_range(6, 7));
    else op.offset = 3'($urandom_range(0, 5));
    op.wdata = rand_word();
    if (op.func == pit_pkg::FN_WRITE) begin
      pick = $urandom_range(0, 99);
      w = rand_word();
      case (op.offset)
        pit_pkg::OFF_TICKS: begin
          if (pick < 40) op.wdata = 64'($urandom_range(0, 200));
          else if (pick < 60) op.wdata = MAX_POS - 64'($urandom_range(0, 20));
        end
        pit_pkg::OFF_INTERVAL: begin
          w[63] = 1'b0;
          if (pick < 60) op.wdata = 64'($urandom_range(1, 12));
          else if (pick < 70) op.wdata = '0;
          else if (pick < 80) op.wdata = {1'b1, w[62:0]};
          else op.wdata = w;
        end
        pit_pkg::OFF_ENABLE: begin
          if (pick < 30) op.wdata = '0;
          else if (pick < 70) op.wdata = 64'd1;
        end
        pit_pkg::OFF_VECTOR: begin
          if (pick < 70) op.wdata = 64'($urandom_range(0, 255));
          else if (pick < 85) op.wdata = 64'($urandom_range(256, 1000));
        end
        pit_pkg::OFF_IRQ_COUNT: if (pick < 70) op.wdata = '0;
        default: ;
      endcase
    end
    return op;
  endfunction

  task automatic queue_random(int n);
    repeat (n) bus_ops.push_back(random_op());
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("reply %0d: %s got %h want %h", reply_cnt, field, got, want);
  endtask

  // wait until every offered transaction has its reply, then let the divider drain
  task automatic wait_quiet();
    @(posedge clk);
    while (bus_ops.size() != 0 || in_ch.valid || timer_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_cfg(idx, data);
  endtask

  task automatic set_timer_cfg(logic [63:0] ival, logic [63:0] vec, logic [63:0] pay);
    wait_quiet();
    write_cfg(pit_pkg::CFG_INTERVAL, ival);
    write_cfg(pit_pkg::CFG_VECTOR, vec);
    write_cfg(pit_pkg::CFG_PAYLOAD, pay);
  endtask

  // sender: bursts of transactions separated by random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    bus_op_t op;
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.func        <= pit_pkg::FN_TICK;
      in_ch.offset      <= pit_pkg::OFF_TICKS;
      in_ch.write_value <= '0;
    end else if (in_ch.valid && !in_fire) begin
      // hold the offered transaction
    end else if (gap_left > 0) begin
      gap_left--;
      in_ch.valid <= 1'b0;
    end else if (bus_ops.size() != 0) begin
      op = bus_ops.pop_front();
      in_ch.func        <= op.func;
      in_ch.offset      <= op.offset;
      in_ch.write_value <= op.wdata;
      in_ch.valid       <= 1'b1;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 10);
      end
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // receiver: stall pattern of its own, plus two long hold-offs under load
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       hold_left  = 0;
  int       holds_done = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (in_ch.valid && ((holds_done == 0 && taken_cnt >= 100) ||
                                 (holds_done == 1 && taken_cnt >= 700))) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_ch.ready <= !out_ch.ready;
        default:   out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: check replies first, then predict for the transaction taken at this edge
  always @(posedge clk) begin
    timer_reply_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (timer_replies.size() == 0) begin
          report_mismatch("unexpected reply, status", 64'(out_ch.status), '0);
        end else begin
          want = timer_replies.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 64'(out_ch.status), 64'(want.status));
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.irq_valid !== want.irq_valid)
            report_mismatch("irq_valid", 64'(out_ch.irq_valid), 64'(want.irq_valid));
          if (out_ch.irq_vector !== want.irq_vector)
            report_mismatch("irq_vector", 64'(out_ch.irq_vector), 64'(want.irq_vector));
          if (out_ch.irq_payload !== want.irq_payload)
            report_mismatch("irq_payload", out_ch.irq_payload, want.irq_payload);
        end
        reply_cnt++;
      end
      if (in_ch.valid && in_ch.ready) begin
        timer_replies.push_back(advance_timer(mk_op(in_ch.func, in_ch.offset,
                                                    in_ch.write_value)));
        taken_cnt++;
      end
    end
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    cfg_we    = 1'b0;
    cfg_index = pit_pkg::CFG_INTERVAL;
    cfg_data  = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values of every register, then an interrupt at interval one
    for (int i = pit_pkg::OFF_TICKS; i <= pit_pkg::OFF_IRQ_COUNT; i++)
      bus_ops.push_back(mk_op(pit_pkg::FN_READ, 3'(i), '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_TICK, pit_pkg::OFF_TICKS, '0));
    bus_ops.push_back(mk_op(FN_UNUSED, pit_pkg::OFF_TICKS, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_READ, OFF_SPARE0, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, OFF_SPARE1, 64'd1));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_TICKS, MIN_NEG));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_INTERVAL, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_INTERVAL, '1));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_INTERVAL, 64'd3));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_VECTOR, 64'd256));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_VECTOR, 64'd255));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_PAYLOAD, MIN_NEG));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_IRQ_COUNT, 64'd5));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_IRQ_COUNT, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_TICKS, MAX_POS - 64'd2));
    // offset and data of a tick are don't-care
    bus_ops.push_back(mk_op(pit_pkg::FN_TICK, OFF_SPARE1, '1));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_ENABLE, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_TICK, pit_pkg::OFF_TICKS, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_ENABLE, MIN_NEG));
    bus_ops.push_back(mk_op(pit_pkg::FN_READ, pit_pkg::OFF_ENABLE, '1));

    // interval beyond the bus-writable range: fires only when the count reaches it
    set_timer_cfg(MIN_NEG, 64'hA5, MAX_POS);
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_ENABLE, 64'd1));
    bus_ops.push_back(mk_op(pit_pkg::FN_WRITE, pit_pkg::OFF_TICKS, MAX_POS));
    bus_ops.push_back(mk_op(pit_pkg::FN_TICK, pit_pkg::OFF_TICKS, '0));
    bus_ops.push_back(mk_op(pit_pkg::FN_READ, pit_pkg::OFF_IRQ_COUNT, '0));
    queue_random(RANDOM_PER_PHASE);

    set_timer_cfg(64'd2, 64'hFFFF_FFFF_FFFF_FF3C, MIN_NEG);
    write_cfg(pit_pkg::CFG_INTERVAL, '0);
    write_cfg(CFG_UNUSED, rand_word());
    queue_random(RANDOM_PER_PHASE);

    set_timer_cfg('1, '0, '1);
    queue_random(RANDOM_PER_PHASE);

    set_timer_cfg(64'd1, 64'd255, '0);
    queue_random(RANDOM_PER_PHASE);

    set_timer_cfg(64'($urandom_range(1, 16)), rand_word(), rand_word());
    write_cfg(CFG_UNUSED, '1);
    queue_random(RANDOM_PER_PHASE);

    set_timer_cfg(64'($urandom_range(2, 6)), rand_word(), rand_word());
    queue_random(RANDOM_PER_PHASE);

    wait_quiet();
    if (mismatches == 0 && timer_replies.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
